### design/bcra_pkg.sv
// Shared types, field widths, opcodes and bit-search helpers for the run allocator.
package bcra_pkg;

    localparam int unsigned IDX_W   = 13;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned LEN_W   = 14;
    localparam int unsigned START_W = 19;
    localparam int unsigned POS_W   = 7;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_WRITE = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_ALLOC = 2'd2;

    // Per-word summary handed from the evaluation stage to the scan decision
    typedef struct packed {
        logic [POS_W-1:0]  first_used;  // index of lowest used bit, 64 when none
        logic [POS_W-1:0]  top_free;    // free bits above the highest used bit
        logic [DATA_W-1:0] win;         // bit j set: a whole run ends at bit j
    } word_eval_t;

    // Index of the lowest set bit, 64 when the vector is clear
    function automatic logic [POS_W-1:0] lowest_set(input logic [DATA_W-1:0] v);
        logic [POS_W-1:0] pos;
        pos = POS_W'(DATA_W);
        for (int i = DATA_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    // Number of clear bits above the highest set bit, 64 when the vector is clear
    function automatic logic [POS_W-1:0] clear_above(input logic [DATA_W-1:0] v);
        logic [POS_W-1:0] cnt;
        cnt = POS_W'(DATA_W);
        for (int i = 0; i < DATA_W; i++)
        begin
            if (v[i])
            begin
                cnt = POS_W'(DATA_W - 1 - i);
            end
        end
        return cnt;
    endfunction

    // Bit j set when free[j-n+1..j] are all set; n below 64, built by doubling
    function automatic logic [DATA_W-1:0] run_ends(input logic [DATA_W-1:0] free,
                                                   input logic [5:0] n);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] p;
        logic              empty;
        a     = free;
        p     = '1;
        empty = 1'b1;
        for (int b = 0; b < 6; b++)
        begin
            if (n[b])
            begin
                p     = empty ? a : ((p << (1 << b)) & a);
                empty = 1'b0;
            end
            a = a & (a << (1 << b));
        end
        return p;
    endfunction

endpackage

### design/bcra_req_if.sv
// Request channel: valid/ready handshake carrying one command item.
interface bcra_req_if;
    logic                             valid;
    logic                             ready;
    bcra_pkg::opcode_t                opcode;
    logic [bcra_pkg::IDX_W-1:0]       word_index;
    logic [bcra_pkg::DATA_W-1:0]      word_data;
    logic [bcra_pkg::LEN_W-1:0]       run_length;

    modport source (output valid, output opcode, output word_index, output word_data,
                    output run_length, input ready);
    modport sink   (input valid, input opcode, input word_index, input word_data,
                    input run_length, output ready);
endinterface

### design/bcra_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
interface bcra_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [bcra_pkg::START_W-1:0]     start_bit;
    logic [bcra_pkg::DATA_W-1:0]      read_word;

    modport source (output valid, output found, output start_bit, output read_word,
                    input ready);
    modport sink   (input valid, input found, input start_bit, input read_word,
                    output ready);
endinterface

### design/bcra_mem.sv
// Bitmap store: one write port and one registered read port.
module bcra_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [bcra_pkg::DATA_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [bcra_pkg::DATA_W-1:0] rdata
);

    logic [bcra_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bcra_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bcra_weval.sv
// Word evaluation stage: summarises one bitmap word for the first-fit scan.
module bcra_weval #(
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        word_valid,
    input  logic [ADDR_W-1:0]           word_idx,
    input  logic [bcra_pkg::DATA_W-1:0] word,
    input  logic [bcra_pkg::LEN_W-1:0]  run_len,
    output logic                        eval_valid,
    output logic [ADDR_W-1:0]           eval_idx,
    output bcra_pkg::word_eval_t        eval
);

    bcra_pkg::word_eval_t eval_next;
    bcra_pkg::word_eval_t eval_reg;
    logic                 valid_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic                 short_run;

    // runs of 64 or more can only grow from bit 0, so no in-word window then
    assign short_run = (run_len[bcra_pkg::LEN_W-1:6] == '0);

    always_comb
    begin
        eval_next.first_used = bcra_pkg::lowest_set(word);
        eval_next.top_free   = bcra_pkg::clear_above(word);
        eval_next.win        = short_run ? bcra_pkg::run_ends(~word, run_len[5:0]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            eval_reg  <= '0;
        end
        else
        begin
            valid_reg <= word_valid;
            idx_reg   <= word_idx;
            eval_reg  <= eval_next;
        end
    end

    assign eval_valid = valid_reg;
    assign eval_idx   = idx_reg;
    assign eval       = eval_reg;

endmodule

### design/bitmap_contiguous_run_allocator.sv
// Top level: first-fit contiguous run allocator over a block-usage bitmap.
// The bitmap lives in one memory with a write port and a registered read port.
// A write item goes straight to the response state and a read passes through a read-wait
// state first; either result then moves into the response register once it is free. An allocate
// streams the map through the read port one word per cycle until the run completes or
// the last word has been evaluated with nothing fitting; a found run is then marked by
// read-modify-write, one word per cycle. Lengths of zero, above MAX_RUN or above the
// map size answer without a scan. One item is worked on at a time; the next request is
// taken as soon as the previous result has moved into the response register, even if
// that register has not yet been drained.
module bitmap_contiguous_run_allocator #(
    parameter int MAP_WORDS = 8192,
    parameter int MAX_RUN   = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    bcra_req_if.sink    req,
    bcra_rsp_if.source  rsp
);

    localparam int          LEN_W      = bcra_pkg::LEN_W;
    localparam int          START_W    = bcra_pkg::START_W;
    localparam int          DATA_W     = bcra_pkg::DATA_W;
    localparam int          ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int          BIT_W      = ADDR_W + 6;
    localparam int          CALC_W     = ((BIT_W > LEN_W) ? BIT_W : LEN_W) + 1;
    localparam int unsigned TOTAL_BITS = MAP_WORDS * 64;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;

    // item and result holding
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 res_found_reg, res_found_next;
    logic [START_W-1:0]   res_start_reg, res_start_next;
    logic [DATA_W-1:0]    res_word_reg, res_word_next;

    // scan pipeline
    logic [ADDR_W-1:0]    rd_addr_reg, rd_addr_next;
    logic                 scan_more_reg, scan_more_next;
    logic                 v1_reg, v1_next;
    logic [ADDR_W-1:0]    w1_reg, w1_next;
    logic [LEN_W-1:0]     carry_reg, carry_next;

    // marking
    logic [CALC_W-1:0]    mk_start_reg, mk_start_next;
    logic [CALC_W-1:0]    mk_end_reg, mk_end_next;
    logic [ADDR_W-1:0]    mk_addr_reg, mk_addr_next;
    logic                 mk_more_reg, mk_more_next;
    logic                 mk_wv_reg, mk_wv_next;
    logic [ADDR_W-1:0]    mk_wa_reg, mk_wa_next;

    // response register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [START_W-1:0]   out_start_reg, out_start_next;
    logic [DATA_W-1:0]    out_word_reg, out_word_next;

    // memory ports
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [DATA_W-1:0]    mem_rdata;

    // evaluation stage outputs
    logic                 ev_valid;
    logic [ADDR_W-1:0]    ev_idx;
    bcra_pkg::word_eval_t ev;

    logic                 idx_ok;
    logic                 len_ok;
    logic [ADDR_W-1:0]    req_addr;
    logic                 out_free;

    logic [LEN_W-1:0]     need;
    logic                 prefix_hit;
    logic [bcra_pkg::POS_W-1:0] win_pos;
    logic                 hit;
    logic [CALC_W-1:0]    wbase;
    logic [CALC_W-1:0]    start_pre;
    logic [CALC_W-1:0]    start_win;
    logic [CALC_W-1:0]    hit_start;
    logic [LEN_W-1:0]     carry_adv;

    logic [ADDR_W-1:0]    mk_first_word;
    logic [ADDR_W-1:0]    mk_last_word;
    logic [5:0]           mk_lo;
    logic [5:0]           mk_hi;
    logic [DATA_W-1:0]    mark_mask;

    bcra_mem #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bcra_weval #(
        .ADDR_W (ADDR_W)
    ) u_weval (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (v1_reg),
        .word_idx   (w1_reg),
        .word       (mem_rdata),
        .run_len    (len_reg),
        .eval_valid (ev_valid),
        .eval_idx   (ev_idx),
        .eval       (ev)
    );

    // request checks
    assign idx_ok   = (32'(req.word_index) < 32'(MAP_WORDS));
    assign len_ok   = (req.run_length != '0) &&
                      (32'(req.run_length) <= 32'(MAX_RUN)) &&
                      (32'(req.run_length) <= TOTAL_BITS);
    assign req_addr = ADDR_W'(req.word_index);
    assign out_free = !out_valid_reg || rsp.ready;

    // first-fit decision for the evaluated word; carry holds the free bits
    // that run into it from the words before
    assign need       = len_reg - carry_reg;
    assign prefix_hit = (need <= LEN_W'(ev.first_used));
    assign win_pos    = bcra_pkg::lowest_set(ev.win);
    assign hit        = prefix_hit || !win_pos[6];
    assign wbase      = CALC_W'({ev_idx, 6'b0});
    assign start_pre  = wbase - CALC_W'(carry_reg);
    assign start_win  = wbase + CALC_W'(win_pos[5:0]) + CALC_W'(1) - CALC_W'(len_reg);
    assign hit_start  = prefix_hit ? start_pre : start_win;
    assign carry_adv  = ev.first_used[6] ? (carry_reg + LEN_W'(64)) : LEN_W'(ev.top_free);

    // mask of run bits inside the word being written back
    assign mk_first_word = mk_start_reg[ADDR_W+5:6];
    assign mk_last_word  = mk_end_reg[ADDR_W+5:6];
    assign mk_lo         = (mk_wa_reg == mk_first_word) ? mk_start_reg[5:0] : 6'd0;
    assign mk_hi         = (mk_wa_reg == mk_last_word) ? mk_end_reg[5:0] : 6'd63;
    assign mark_mask     = ({DATA_W{1'b1}} << mk_lo) & ({DATA_W{1'b1}} >> (6'd63 - mk_hi));

    // sequencer and memory port control
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_word_next  = res_word_reg;
        rd_addr_next   = rd_addr_reg;
        scan_more_next = scan_more_reg;
        v1_next        = 1'b0;
        w1_next        = w1_reg;
        carry_next     = carry_reg;
        mk_start_next  = mk_start_reg;
        mk_end_next    = mk_end_reg;
        mk_addr_next   = mk_addr_reg;
        mk_more_next   = mk_more_reg;
        mk_wv_next     = 1'b0;
        mk_wa_next     = mk_wa_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        out_word_next  = out_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = mk_wa_reg;
        mem_wdata      = mem_rdata | mark_mask;
        mem_re         = 1'b0;
        mem_raddr      = rd_addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    res_word_next  = '0;
                    state_next     = ST_RESP;
                    unique case (req.opcode)
                        bcra_pkg::OP_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = req_addr;
                                mem_wdata     = req.word_data;
                                res_word_next = req.word_data;
                            end
                        end
                        bcra_pkg::OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = req_addr;
                                state_next = ST_RD_WAIT;
                            end
                        end
                        bcra_pkg::OP_ALLOC:
                        begin
                            len_next = req.run_length;
                            if (len_ok)
                            begin
                                rd_addr_next   = '0;
                                scan_more_next = 1'b1;
                                carry_next     = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                res_word_next = mem_rdata;
                state_next    = ST_RESP;
            end

            ST_SCAN:
            begin
                // issue the next word read
                if (scan_more_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_addr_reg;
                    v1_next   = 1'b1;
                    w1_next   = rd_addr_reg;
                    if (rd_addr_reg == LAST_WORD)
                    begin
                        scan_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                end
                // decide on the evaluated word; reads still in flight are dropped
                if (ev_valid)
                begin
                    if (hit)
                    begin
                        mk_start_next = hit_start;
                        mk_end_next   = hit_start + CALC_W'(len_reg) - CALC_W'(1);
                        mk_addr_next  = hit_start[ADDR_W+5:6];
                        mk_more_next  = 1'b1;
                        state_next    = ST_MARK;
                    end
                    else
                    begin
                        carry_next = carry_adv;
                        if (ev_idx == LAST_WORD)
                        begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                // read ahead while the previous word is written back
                if (mk_more_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mk_addr_reg;
                    mk_wv_next = 1'b1;
                    mk_wa_next = mk_addr_reg;
                    if (mk_addr_reg == mk_last_word)
                    begin
                        mk_more_next = 1'b0;
                    end
                    else
                    begin
                        mk_addr_next = mk_addr_reg + ADDR_W'(1);
                    end
                end
                if (mk_wv_reg)
                begin
                    mem_we = 1'b1;
                    if (mk_wa_reg == mk_last_word)
                    begin
                        res_found_next = 1'b1;
                        res_start_next = START_W'(mk_start_reg);
                        state_next     = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_start_next = res_start_reg;
                    out_word_next  = res_word_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            res_found_reg <= 1'b0;
            res_start_reg <= '0;
            res_word_reg  <= '0;
            rd_addr_reg   <= '0;
            scan_more_reg <= 1'b0;
            v1_reg        <= 1'b0;
            w1_reg        <= '0;
            carry_reg     <= '0;
            mk_start_reg  <= '0;
            mk_end_reg    <= '0;
            mk_addr_reg   <= '0;
            mk_more_reg   <= 1'b0;
            mk_wv_reg     <= 1'b0;
            mk_wa_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            res_found_reg <= res_found_next;
            res_start_reg <= res_start_next;
            res_word_reg  <= res_word_next;
            rd_addr_reg   <= rd_addr_next;
            scan_more_reg <= scan_more_next;
            v1_reg        <= v1_next;
            w1_reg        <= w1_next;
            carry_reg     <= carry_next;
            mk_start_reg  <= mk_start_next;
            mk_end_reg    <= mk_end_next;
            mk_addr_reg   <= mk_addr_next;
            mk_more_reg   <= mk_more_next;
            mk_wv_reg     <= mk_wv_next;
            mk_wa_reg     <= mk_wa_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.start_bit = out_start_reg;
    assign rsp.read_word = out_word_reg;

    // the free run carried into a word never already covers the request
    a_carry_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && ev_valid) |-> (carry_reg < len_reg))
        else $error("carried run reached the requested length unnoticed");

    // write-back stays inside the words spanned by the found run
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK && mem_we) |->
            (mk_wa_reg >= mk_first_word && mk_wa_reg <= mk_last_word))
        else $error("mark write outside the allocated run");

    // every word written back gains at least one run bit
    a_mark_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK && mk_wv_reg) |-> (mark_mask != '0))
        else $error("empty mark mask on write-back");

    // a new response only comes from the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("response raised outside the response state");

endmodule
